[design/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the HEX record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

   // Input word: one text character or the end-of-input marker
   typedef struct packed {
      logic       operation;
      logic [7:0] character;
   } req_type;

   // Result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic [7:0]  record_type;
      logic [2:0]  error_code;
   } rsp_type;

   // Operation codes
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_RECORD = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_COLON  = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
   localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd4;
   localparam logic [2:0] ERR_EXT_LEN   = 3'd5;
   localparam logic [2:0] ERR_NO_END    = 3'd6;

   // Record types
   localparam logic [7:0] REC_DATA     = 8'h00;
   localparam logic [7:0] REC_EOF      = 8'h01;
   localparam logic [7:0] REC_EXT_LIN  = 8'h04;
   localparam logic [7:0] REC_START    = 8'h05;

   // Extended linear address record carries exactly two bytes
   localparam logic [7:0] EXT_LIN_LEN  = 8'h02;

   // Characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_AWAIT = 6'b000001,
      PH_LEN   = 6'b000010,
      PH_ADDR  = 6'b000100,
      PH_TYPE  = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_CKS   = 6'b100000
   } phase_type;

   // Hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/intel_hex_record_parser.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// HEX text stream parser: characters in, data bytes and record status out.
// ----------------------------------------------------------------------------
// One word is accepted per clock cycle, sustained, while rsp_ready stays
// high. Each word passes through an input register, the parser state
// update, and a result register; its result is loaded into the result
// register when the word leaves the input register. Words that produce no
// result (colon, line breaks, hex digits that do not complete a data byte,
// a type field that passes its checks, characters after an error) still pass
// through the input register and the core. When the result register is full
// and not taken, the input register holds and req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ihex_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ihex_pkg::rsp_type      rsp_payload
);

   logic              held_valid;
   ihex_pkg::req_type held_item;
   logic              advance;
   logic              room;
   logic              has_result;
   ihex_pkg::rsp_type result;

   // Held word moves into the core when the result side has room
   assign advance = held_valid && room;

   ihex_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .held_valid  (held_valid),
      .held_item   (held_item)
   );

   ihex_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (held_item),
      .has_result (has_result),
      .result     (result)
   );

   ihex_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .has_result  (has_result),
      .result      (result),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[design/ihex_in_stage.sv]
// ----------------------------------------------------------------------------
// ihex_in_stage
// Input register: holds one accepted word until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ihex_pkg::req_type req_payload,
   input  wire logic             advance,
   output logic                  held_valid,
   output ihex_pkg::req_type     held_item
);

   logic              valid_ff, valid_in;
   ihex_pkg::req_type item_ff;

   // Free when empty or when the held word moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_payload;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

`default_nettype wire

[design/ihex_core.sv]
// ----------------------------------------------------------------------------
// ihex_core
// Record parser state and the per-character update; yields at most one
// result word for each word it consumes.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire ihex_pkg::req_type item,
   output logic                   has_result,
   output ihex_pkg::rsp_type      result
);

   // State registers
   ihex_pkg::phase_type phase_ff, phase_in;
   logic        low_next_ff, low_next_in;
   logic [3:0]  high_nib_ff, high_nib_in;
   logic        field_idx_ff, field_idx_in;
   logic [7:0]  rec_len_ff, rec_len_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  data_idx_ff, data_idx_in;
   logic [15:0] pend_page_ff, pend_page_in;
   logic [15:0] page_ff, page_in;
   logic        err_ff, err_in;
   logic        last_end_ff, last_end_in;

   logic [4:0]  hex;
   logic [7:0]  byte_val;
   logic [7:0]  sum_next;
   logic [7:0]  left_next;
   logic [31:0] data_addr;

   assign hex       = ihex_pkg::hex_decode(item.character);
   assign byte_val  = {high_nib_ff, hex[3:0]};
   assign sum_next  = sum_ff + byte_val;
   assign left_next = bytes_left_ff - 8'd1;
   assign data_addr = {page_ff, 16'h0000} + {16'h0000, offset_ff} + {24'h000000, data_idx_ff};

   // Next-state and result logic
   always_comb begin
      phase_in     = phase_ff;
      low_next_in  = low_next_ff;
      high_nib_in  = high_nib_ff;
      field_idx_in = field_idx_ff;
      rec_len_in   = rec_len_ff;
      bytes_left_in = bytes_left_ff;
      offset_in    = offset_ff;
      type_in      = type_ff;
      sum_in       = sum_ff;
      data_idx_in  = data_idx_ff;
      pend_page_in = pend_page_ff;
      page_in      = page_ff;
      err_in       = err_ff;
      last_end_in  = last_end_ff;
      has_result   = 1'b0;
      result       = '0;

      if (item.operation == ihex_pkg::OP_END) begin
         // Final status, then back to the reset state
         has_result = 1'b1;
         if (!err_ff && phase_ff == ihex_pkg::PH_AWAIT && last_end_ff) begin
            result.kind = ihex_pkg::KIND_DONE;
         end else begin
            result.kind       = ihex_pkg::KIND_ERROR;
            result.error_code = ihex_pkg::ERR_NO_END;
         end
         phase_in      = ihex_pkg::PH_AWAIT;
         low_next_in   = 1'b0;
         high_nib_in   = '0;
         field_idx_in  = 1'b0;
         rec_len_in    = '0;
         bytes_left_in = '0;
         offset_in     = '0;
         type_in       = '0;
         sum_in        = '0;
         data_idx_in   = '0;
         pend_page_in  = '0;
         page_in       = '0;
         err_in        = 1'b0;
         last_end_in   = 1'b0;
      end else if (!err_ff) begin
         if (phase_ff == ihex_pkg::PH_AWAIT) begin
            // Between records: skip line breaks, expect a colon
            if (item.character == ihex_pkg::CHAR_COLON) begin
               phase_in     = ihex_pkg::PH_LEN;
               low_next_in  = 1'b0;
               field_idx_in = 1'b0;
               sum_in       = '0;
               data_idx_in  = '0;
               offset_in    = '0;
            end else if (item.character != ihex_pkg::CHAR_CR &&
                         item.character != ihex_pkg::CHAR_LF) begin
               has_result        = 1'b1;
               result.kind       = ihex_pkg::KIND_ERROR;
               result.error_code = ihex_pkg::ERR_NO_COLON;
               err_in            = 1'b1;
            end
         end else if (!hex[4]) begin
            has_result        = 1'b1;
            result.kind       = ihex_pkg::KIND_ERROR;
            result.error_code = ihex_pkg::ERR_BAD_HEX;
            err_in            = 1'b1;
         end else if (!low_next_ff) begin
            high_nib_in = hex[3:0];
            low_next_in = 1'b1;
         end else begin
            // A full byte of the record
            low_next_in = 1'b0;
            sum_in      = sum_next;
            unique case (phase_ff)
               ihex_pkg::PH_LEN: begin
                  rec_len_in    = byte_val;
                  bytes_left_in = byte_val;
                  field_idx_in  = 1'b0;
                  phase_in      = ihex_pkg::PH_ADDR;
               end
               ihex_pkg::PH_ADDR: begin
                  offset_in    = {offset_ff[7:0], byte_val};
                  field_idx_in = !field_idx_ff;
                  if (field_idx_ff) begin
                     phase_in = ihex_pkg::PH_TYPE;
                  end
               end
               ihex_pkg::PH_TYPE: begin
                  type_in = byte_val;
                  if (byte_val != ihex_pkg::REC_DATA && byte_val != ihex_pkg::REC_EOF &&
                      byte_val != ihex_pkg::REC_EXT_LIN && byte_val != ihex_pkg::REC_START) begin
                     has_result        = 1'b1;
                     result.kind       = ihex_pkg::KIND_ERROR;
                     result.error_code = ihex_pkg::ERR_BAD_TYPE;
                     err_in            = 1'b1;
                  end else if (byte_val == ihex_pkg::REC_EXT_LIN &&
                               rec_len_ff != ihex_pkg::EXT_LIN_LEN) begin
                     has_result        = 1'b1;
                     result.kind       = ihex_pkg::KIND_ERROR;
                     result.error_code = ihex_pkg::ERR_EXT_LEN;
                     err_in            = 1'b1;
                  end else begin
                     phase_in = (bytes_left_ff != 8'd0) ? ihex_pkg::PH_DATA
                                                        : ihex_pkg::PH_CKS;
                  end
               end
               ihex_pkg::PH_DATA: begin
                  if (type_ff == ihex_pkg::REC_DATA) begin
                     has_result       = 1'b1;
                     result.kind      = ihex_pkg::KIND_DATA;
                     result.address   = data_addr;
                     result.data_byte = byte_val;
                  end else if (type_ff == ihex_pkg::REC_EXT_LIN) begin
                     pend_page_in = {pend_page_ff[7:0], byte_val};
                  end
                  data_idx_in   = data_idx_ff + 8'd1;
                  bytes_left_in = left_next;
                  if (left_next == 8'd0) begin
                     phase_in = ihex_pkg::PH_CKS;
                  end
               end
               ihex_pkg::PH_CKS: begin
                  if (sum_next != 8'd0) begin
                     has_result        = 1'b1;
                     result.kind       = ihex_pkg::KIND_ERROR;
                     result.error_code = ihex_pkg::ERR_CHECKSUM;
                     err_in            = 1'b1;
                  end else begin
                     if (type_ff == ihex_pkg::REC_EXT_LIN) begin
                        page_in = pend_page_ff;
                     end
                     last_end_in = (type_ff == ihex_pkg::REC_EOF) && (rec_len_ff == 8'd0) &&
                                   (offset_ff == 16'h0000);
                     phase_in           = ihex_pkg::PH_AWAIT;
                     has_result         = 1'b1;
                     result.kind        = ihex_pkg::KIND_RECORD;
                     result.record_type = type_ff;
                  end
               end
               default: begin
                  phase_in = ihex_pkg::PH_AWAIT;
               end
            endcase
         end
      end
   end

   // State update, once per consumed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ihex_pkg::PH_AWAIT;
         low_next_ff   <= 1'b0;
         high_nib_ff   <= '0;
         field_idx_ff  <= 1'b0;
         rec_len_ff    <= '0;
         bytes_left_ff <= '0;
         offset_ff     <= '0;
         type_ff       <= '0;
         sum_ff        <= '0;
         data_idx_ff   <= '0;
         pend_page_ff  <= '0;
         page_ff       <= '0;
         err_ff        <= 1'b0;
         last_end_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         low_next_ff   <= low_next_in;
         high_nib_ff   <= high_nib_in;
         field_idx_ff  <= field_idx_in;
         rec_len_ff    <= rec_len_in;
         bytes_left_ff <= bytes_left_in;
         offset_ff     <= offset_in;
         type_ff       <= type_in;
         sum_ff        <= sum_in;
         data_idx_ff   <= data_idx_in;
         pend_page_ff  <= pend_page_in;
         page_ff       <= page_in;
         err_ff        <= err_in;
         last_end_ff   <= last_end_in;
      end
   end

endmodule

`default_nettype wire

[design/ihex_out_stage.sv]
// ----------------------------------------------------------------------------
// ihex_out_stage
// Result register: holds a finished word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              has_result,
   input  wire ihex_pkg::rsp_type result,
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ihex_pkg::rsp_type      rsp_payload
);

   logic              valid_ff, valid_in;
   ihex_pkg::rsp_type item_ff;

   // Room when empty or the held word leaves this cycle
   assign room     = !valid_ff || rsp_ready;
   assign valid_in = advance ? has_result : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         item_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = item_ff;

endmodule

`default_nettype wire

[test/intel_hex_record_parser_tb.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser_tb
// Self-checking bench for the HEX record parser. Streams of characters are
// built from records with random content (data, extended linear address,
// start address, end of file) and mixed-case digits. Some streams carry one
// fault: bad digit, bad checksum, bad type, bad extended length, stray
// character, cut-short record or missing end record. A scoreboard predicts
// every result word and checks the output in order, under random stalls.
// ----------------------------------------------------------------------------

module intel_hex_record_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int WORD_TARGET = 1650;

   typedef enum int {
      FAULT_NONE, FAULT_HEX, FAULT_CSUM, FAULT_TYPE,
      FAULT_EXT_LEN, FAULT_STRAY, FAULT_CUT, FAULT_NO_EOF
   } fault_type;

   // Parser model plus in-order store of the result words it predicts
   class hex_scoreboard;
      ihex_pkg::rsp_type   expected_results[$];
      int                  mismatch_count;
      int                  parsed_words;
      ihex_pkg::phase_type stage;
      bit         low_due;
      bit         offset_half;
      logic [3:0] hi_nib;
      logic [7:0] rec_len;
      logic [7:0] left;
      logic [7:0] rec_type;
      logic [7:0] csum;
      logic [7:0] idx;
      logic [15:0] offset;
      logic [15:0] page_next;
      logic [15:0] page;
      bit         failed;
      bit         eof_seen;

      function new();
         mismatch_count = 0;
         parsed_words = 0;
         clear_state();
      endfunction

      function void clear_state();
         stage = ihex_pkg::PH_AWAIT;
         low_due = 1'b0;
         offset_half = 1'b0;
         hi_nib = '0;
         rec_len = '0;
         left = '0;
         rec_type = '0;
         csum = '0;
         idx = '0;
         offset = '0;
         page_next = '0;
         page = '0;
         failed = 1'b0;
         eof_seen = 1'b0;
      endfunction

      // bit 4 flags a valid digit, bits 3:0 hold its value
      function logic [4:0] digit_value(logic [7:0] c);
         logic [7:0] v;
         if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
         end else if (c >= "A" && c <= "F") begin
            v = c - 8'h37;
         end else if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
         end else begin
            return 5'd0;
         end
         return {1'b1, v[3:0]};
      endfunction

      function bit flag_error(output ihex_pkg::rsp_type r, input logic [2:0] code);
         failed = 1'b1;
         r = '0;
         r.kind = ihex_pkg::KIND_ERROR;
         r.error_code = code;
         return 1'b1;
      endfunction

      function bit predict(ihex_pkg::req_type w, output ihex_pkg::rsp_type r);
         logic [4:0] dig;
         logic [7:0] b;
         bit hit;
         r = '0;
         hit = 1'b0;
         // end of input: report and start over
         if (w.operation == ihex_pkg::OP_END) begin
            if (!failed && stage == ihex_pkg::PH_AWAIT && eof_seen) begin
               r.kind = ihex_pkg::KIND_DONE;
            end else begin
               r.kind = ihex_pkg::KIND_ERROR;
               r.error_code = ihex_pkg::ERR_NO_END;
            end
            clear_state();
            return 1'b1;
         end
         if (failed) return 1'b0;
         // between records
         if (stage == ihex_pkg::PH_AWAIT) begin
            if (w.character == ihex_pkg::CHAR_CR || w.character == ihex_pkg::CHAR_LF)
               return 1'b0;
            if (w.character != ihex_pkg::CHAR_COLON)
               return flag_error(r, ihex_pkg::ERR_NO_COLON);
            stage = ihex_pkg::PH_LEN;
            low_due = 1'b0;
            offset_half = 1'b0;
            csum = '0;
            idx = '0;
            offset = '0;
            return 1'b0;
         end
         dig = digit_value(w.character);
         if (!dig[4]) return flag_error(r, ihex_pkg::ERR_BAD_HEX);
         if (!low_due) begin
            hi_nib = dig[3:0];
            low_due = 1'b1;
            return 1'b0;
         end
         low_due = 1'b0;
         b = {hi_nib, dig[3:0]};
         csum = csum + b;
         case (stage)
            ihex_pkg::PH_LEN: begin
               rec_len = b;
               left = b;
               offset_half = 1'b0;
               stage = ihex_pkg::PH_ADDR;
            end
            ihex_pkg::PH_ADDR: begin
               offset = {offset[7:0], b};
               if (!offset_half) begin
                  offset_half = 1'b1;
               end else begin
                  offset_half = 1'b0;
                  stage = ihex_pkg::PH_TYPE;
               end
            end
            ihex_pkg::PH_TYPE: begin
               rec_type = b;
               if (b != ihex_pkg::REC_DATA && b != ihex_pkg::REC_EOF &&
                   b != ihex_pkg::REC_EXT_LIN && b != ihex_pkg::REC_START)
                  return flag_error(r, ihex_pkg::ERR_BAD_TYPE);
               if (b == ihex_pkg::REC_EXT_LIN && rec_len != ihex_pkg::EXT_LIN_LEN)
                  return flag_error(r, ihex_pkg::ERR_EXT_LEN);
               stage = (left != 0) ? ihex_pkg::PH_DATA : ihex_pkg::PH_CKS;
            end
            ihex_pkg::PH_DATA: begin
               if (rec_type == ihex_pkg::REC_DATA) begin
                  r.kind = ihex_pkg::KIND_DATA;
                  r.address = {page, 16'h0000} + 32'(offset) + 32'(idx);
                  r.data_byte = b;
                  hit = 1'b1;
               end else if (rec_type == ihex_pkg::REC_EXT_LIN) begin
                  page_next = {page_next[7:0], b};
               end
               idx = idx + 8'd1;
               left = left - 8'd1;
               if (left == 0) stage = ihex_pkg::PH_CKS;
            end
            ihex_pkg::PH_CKS: begin
               if (csum != 0) return flag_error(r, ihex_pkg::ERR_CHECKSUM);
               if (rec_type == ihex_pkg::REC_EXT_LIN) page = page_next;
               eof_seen = (rec_type == ihex_pkg::REC_EOF && rec_len == 0 && offset == 0);
               stage = ihex_pkg::PH_AWAIT;
               r.kind = ihex_pkg::KIND_RECORD;
               r.record_type = rec_type;
               hit = 1'b1;
            end
            default: stage = ihex_pkg::PH_AWAIT;
         endcase
         return hit;
      endfunction

      function void note_word(ihex_pkg::req_type w);
         ihex_pkg::rsp_type r;
         if (w.operation == ihex_pkg::OP_END || !failed) parsed_words++;
         if (predict(w, r)) expected_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_word(ihex_pkg::rsp_type got);
         ihex_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word, kind %0d", got.kind));
            return;
         end
         want = expected_results.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.address !== want.address)
            report_mismatch($sformatf("address %h, want %h", got.address, want.address));
         if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("data %h, want %h", got.data_byte, want.data_byte));
         if (got.record_type !== want.record_type)
            report_mismatch($sformatf("type %h, want %h", got.record_type,
                                      want.record_type));
         if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error %0d, want %0d", got.error_code,
                                      want.error_code));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ihex_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ihex_pkg::rsp_type rsp_payload;

   hex_scoreboard     sb;
   ihex_pkg::req_type stream[$];
   logic [7:0]        rec_bytes[$];
   int                idle_pct = 17;
   int                cycle_count = 0;
   bit                big_done = 1'b0;

   intel_hex_record_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // result side: random stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_payload);
   end

   // hard stop
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("intel_hex_record_parser test failed");
      $finish;
   end

   // one word per handshake, with random gaps ahead of it
   task automatic send_word(input ihex_pkg::req_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(w);
   endtask

   task automatic send_stream();
      foreach (stream[i]) send_word(stream[i]);
      stream.delete();
   endtask

   task automatic push_char(input logic [7:0] c);
      stream.push_back({ihex_pkg::OP_CHAR, c});
   endtask

   task automatic push_end();
      stream.push_back({ihex_pkg::OP_END, 8'($urandom_range(0, 255))});
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return 8'h30 + {4'h0, n};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
   endfunction

   task automatic push_hex(input logic [7:0] b);
      push_char(hex_char(b[7:4]));
      push_char(hex_char(b[3:0]));
   endtask

   task automatic push_breaks();
      repeat ($urandom_range(0, 3))
         push_char($urandom_range(0, 1) ? ihex_pkg::CHAR_CR : ihex_pkg::CHAR_LF);
   endtask

   task automatic fill_bytes(input int n);
      rec_bytes.delete();
      repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // full record from rec_bytes; skew != 0 breaks the checksum
   task automatic push_record(input logic [7:0] len, input logic [15:0] ofs,
                              input logic [7:0] rtype, input logic [7:0] skew);
      logic [7:0] total;
      total = len + ofs[15:8] + ofs[7:0] + rtype;
      push_char(ihex_pkg::CHAR_COLON);
      push_hex(len);
      push_hex(ofs[15:8]);
      push_hex(ofs[7:0]);
      push_hex(rtype);
      foreach (rec_bytes[i]) begin
         push_hex(rec_bytes[i]);
         total = total + rec_bytes[i];
      end
      total = 8'h00 - total + skew;
      push_hex(total);
   endtask

   function automatic logic [15:0] pick_offset();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 16'hFFF0 | 16'($urandom_range(0, 15));
      if (roll < 25) return 16'h0000;
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_page();
      int roll;
      roll = $urandom_range(0, 2);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic push_page_record(input logic [15:0] pg, input logic [15:0] ofs,
                                   input logic [7:0] skew);
      rec_bytes.delete();
      rec_bytes.push_back(pg[15:8]);
      rec_bytes.push_back(pg[7:0]);
      push_record(ihex_pkg::EXT_LIN_LEN, ofs, ihex_pkg::REC_EXT_LIN, skew);
   endtask

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      logic [4:0] d;
      do begin
         c = 8'($urandom_range(0, 255));
         d = sb.digit_value(c);
      end while (d[4]);
      return c;
   endfunction

   function automatic logic [7:0] stray_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == ihex_pkg::CHAR_CR || c == ihex_pkg::CHAR_LF ||
             c == ihex_pkg::CHAR_COLON);
      return c;
   endfunction

   // a few records, at most one fault, then end of file if fault-free, and end of input
   task automatic build_file();
      int recs;
      int bad_at;
      int roll;
      int mark;
      fault_type fault;
      fault_type here;
      logic [7:0] len;
      logic [7:0] rtype;
      logic [7:0] skew;
      logic [15:0] ofs;
      recs = $urandom_range(1, 4);
      bad_at = $urandom_range(0, recs - 1);
      fault = FAULT_NONE;
      if ($urandom_range(0, 99) < 45) fault = fault_type'($urandom_range(1, 7));
      push_breaks();
      for (int i = 0; i < recs; i++) begin
         here = (i == bad_at) ? fault : FAULT_NONE;
         skew = (here == FAULT_CSUM) ? 8'($urandom_range(1, 255)) : 8'h00;
         roll = $urandom_range(0, 99);
         ofs = pick_offset();
         mark = stream.size();
         if (!big_done) begin
            // longest record at the top page, so addresses can wrap
            big_done = 1'b1;
            push_page_record(16'hFFFF, pick_offset(), 8'h00);
            mark = stream.size();
            fill_bytes(255);
            push_record(8'd255, ofs, ihex_pkg::REC_DATA, skew);
         end else if (here == FAULT_EXT_LEN) begin
            do len = 8'($urandom_range(0, 6)); while (len == ihex_pkg::EXT_LIN_LEN);
            fill_bytes(int'(len));
            push_record(len, ofs, ihex_pkg::REC_EXT_LIN, skew);
         end else if (here == FAULT_TYPE) begin
            do rtype = 8'($urandom_range(0, 255));
            while (rtype == ihex_pkg::REC_DATA || rtype == ihex_pkg::REC_EOF ||
                   rtype == ihex_pkg::REC_EXT_LIN || rtype == ihex_pkg::REC_START);
            len = 8'($urandom_range(0, 4));
            fill_bytes(int'(len));
            push_record(len, ofs, rtype, skew);
         end else if (roll < 15) begin
            push_page_record(pick_page(), ofs, skew);
         end else if (roll < 27) begin
            len = (roll < 21) ? 8'd4 : 8'($urandom_range(0, 8));
            fill_bytes(int'(len));
            push_record(len, ofs, ihex_pkg::REC_START, skew);
         end else if (roll < 34) begin
            // end-of-file type in mid stream, well formed or not
            len = 8'($urandom_range(0, 2));
            if (roll < 31) ofs = 16'h0000;
            fill_bytes(int'(len));
            push_record(len, ofs, ihex_pkg::REC_EOF, skew);
         end else begin
            len = (roll < 37) ? 8'($urandom_range(9, 40)) : 8'($urandom_range(0, 8));
            fill_bytes(int'(len));
            push_record(len, ofs, ihex_pkg::REC_DATA, skew);
         end
         if (here == FAULT_HEX)
            stream[$urandom_range(mark + 1, stream.size() - 1)] =
               {ihex_pkg::OP_CHAR, non_hex_char()};
         if (here == FAULT_CUT)
            repeat ($urandom_range(1, stream.size() - mark - 1)) void'(stream.pop_back());
         if (here == FAULT_STRAY) push_char(stray_char());
         if (here != FAULT_NONE && here != FAULT_NO_EOF) break;
         push_breaks();
      end
      if (fault == FAULT_NONE) begin
         rec_bytes.delete();
         if ($urandom_range(0, 99) < 85) begin
            push_record(8'h00, 16'h0000, ihex_pkg::REC_EOF, 8'h00);
         end else begin
            fill_bytes(1);
            push_record(8'h01, 16'($urandom_range(0, 65535)), ihex_pkg::REC_EOF, 8'h00);
         end
         push_breaks();
      end
      push_end();
      if ($urandom_range(0, 99) < 8) push_end();
   endtask

   task automatic build_noise();
      repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
      push_end();
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // minimal good file with line breaks
      rec_bytes.delete();
      push_record(8'h00, 16'h0000, ihex_pkg::REC_EOF, 8'h00);
      push_char(ihex_pkg::CHAR_CR);
      push_char(ihex_pkg::CHAR_LF);
      push_end();
      // junk where a colon belongs
      push_char("Z");
      push_end();
      // non-digit with bit 7 set inside a record
      push_char(ihex_pkg::CHAR_COLON);
      push_char(8'hFF);
      push_end();
      // empty input, then a record cut after one digit
      push_end();
      push_char(ihex_pkg::CHAR_COLON);
      push_char("0");
      push_end();
      send_stream();

      // random files; one long stretch runs with no gaps or stalls
      while (sb.parsed_words < WORD_TARGET) begin
         idle_pct = (sb.parsed_words > 700 && sb.parsed_words < 1000) ? 0 : 17;
         if ($urandom_range(0, 99) < 6) build_noise();
         else build_file();
         send_stream();
      end
      req_valid <= 1'b0;

      // drain, then allow for the pipeline latency
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.expected_results.size() != 0)
         sb.report_mismatch($sformatf("%0d words never arrived", sb.expected_results.size()));
      if (sb.mismatch_count == 0) begin
         $display("intel_hex_record_parser test passed");
      end else begin
         $display("intel_hex_record_parser test failed");
      end
      $finish;
   end

endmodule

[files.f]
design/ihex_pkg.sv
design/ihex_in_stage.sv
design/ihex_core.sv
design/ihex_out_stage.sv
design/intel_hex_record_parser.sv
test/intel_hex_record_parser_tb.sv
